/* rtl/core/etc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package etc_pkg;

    localparam int STORE_DEPTH  = 2048;
    localparam int FRAME_WIDTH  = 128;
    localparam int SEARCH_SPAN  = 1024;
    localparam int SAMPLE_BITS  = 10;

    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    localparam int FILL_W       = ADDR_W + 1;
    localparam int FRAME_AW     = $clog2(FRAME_WIDTH);
    localparam int SPAN_W       = $clog2(SEARCH_SPAN);
    localparam int HALF_FRAME   = FRAME_WIDTH / 2;
    localparam int PRE_TRIGGER  = 64;
    localparam int SCALE_DIV    = 24;

    localparam int OP_W         = 2;
    localparam int READ_W       = 7;
    localparam int TIDX_W       = 11;
    localparam int LEVEL_W      = 10;
    localparam int SCALE_W      = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 10;
    localparam int CMP_W        = (SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W;

    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = QPTR_W + 1;

    localparam logic [LEVEL_W-1:0] LEVEL_RESET = 10'd514;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 8'd24;

    localparam logic [OP_W-1:0] OP_STORE   = 2'd0;
    localparam logic [OP_W-1:0] OP_CAPTURE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 2'd2;

    typedef enum logic [1:0] {
        KIND_STORE,
        KIND_CAPTURE,
        KIND_READ
    } kind_t;

    typedef struct packed {
        kind_t                  kind;
        logic [SAMPLE_BITS-1:0] sample;
        logic [FRAME_AW-1:0]    frame_idx;
    } cmd_t;

    typedef struct packed {
        logic              full;
        logic [QCNT_W-1:0] count;
    } qstat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_PRIME,
        ST_SEARCH,
        ST_COPY,
        ST_DRAIN,
        ST_DONE
    } back_state_t;

endpackage
`default_nettype wire

/* rtl/core/edge_trigger_capture_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// Edge trigger capture for a sampling oscilloscope. Items enter a four-deep
// command queue and are carried out in order by an engine that owns the
// sample store and the frame store; a finished result waits in an output
// register, so new items keep being accepted until the queue is full.
// Samples stream at one per cycle while nothing else is queued ahead of
// them. A capture searches back for its crossing over at most SEARCH_SPAN
// positions and, if it finds one, copies a frame; both the backward search
// and the frame copy are bound by the single read port of the sample store.
// The sample store needs no clearing after reset: a fill count marks which
// entries have been written, and the rest read as zero.
module edge_trigger_capture_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [etc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [etc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                           item_valid,
    output logic                                item_ready,
    input  wire logic [etc_pkg::OP_W-1:0]        op,
    input  wire logic [etc_pkg::SAMPLE_BITS-1:0] sample,
    input  wire logic [etc_pkg::READ_W-1:0]      read_index,
    output logic                                result_valid,
    input  wire logic                           result_ready,
    output logic                                found,
    output logic [etc_pkg::TIDX_W-1:0]           trigger_index,
    output logic [etc_pkg::SAMPLE_BITS-1:0]      value
);
    import etc_pkg::*;

    qstat_t q_stat;
    logic   push_valid;
    cmd_t   push_cmd;
    logic   head_valid;
    cmd_t   head_cmd;
    logic   pop;

    etc_front u_front (
        .item_valid (item_valid),
        .item_ready (item_ready),
        .op         (op),
        .sample     (sample),
        .read_index (read_index),
        .q_stat     (q_stat),
        .push_valid (push_valid),
        .push_cmd   (push_cmd)
    );

    etc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .q_stat     (q_stat)
    );

    etc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .head_valid    (head_valid),
        .head_cmd      (head_cmd),
        .pop           (pop),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .found         (found),
        .trigger_index (trigger_index),
        .value         (value)
    );

    // A capture that misses reports index zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !found) |-> (trigger_index == '0))
        else $error("trigger index set without a crossing");

    // A capture result never carries frame data.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && found) |-> (value == '0))
        else $error("capture result carries a frame value");

    // The front must stall once the queue is full.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> !item_ready)
        else $error("item taken while the queue is full");

    // A full queue cannot grow in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |=> (q_stat.count <= QCNT_W'(QUEUE_DEPTH)))
        else $error("queue count beyond its depth");

endmodule
`default_nettype wire

/* rtl/core/etc_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module etc_front (
    input  wire logic                           item_valid,
    output logic                                item_ready,
    input  wire logic [etc_pkg::OP_W-1:0]        op,
    input  wire logic [etc_pkg::SAMPLE_BITS-1:0] sample,
    input  wire logic [etc_pkg::READ_W-1:0]      read_index,
    input  wire etc_pkg::qstat_t                 q_stat,
    output logic                                push_valid,
    output etc_pkg::cmd_t                        push_cmd
);
    import etc_pkg::*;

    logic  keep;
    kind_t kind;

    always_comb
    begin
        keep = 1'b1;
        kind = KIND_STORE;
        case (op)
            OP_STORE:   kind = KIND_STORE;
            OP_CAPTURE: kind = KIND_CAPTURE;
            OP_READ:    kind = KIND_READ;
            // The unused code is taken and dropped here without a result.
            default:    keep = 1'b0;
        endcase
    end

    assign item_ready         = !q_stat.full;
    assign push_valid         = item_valid && !q_stat.full && keep;
    assign push_cmd.kind      = kind;
    assign push_cmd.sample    = sample;
    assign push_cmd.frame_idx = FRAME_AW'(read_index);

endmodule
`default_nettype wire

/* rtl/core/etc_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
module etc_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push_valid,
    input  wire etc_pkg::cmd_t  push_cmd,
    input  wire logic           pop,
    output logic                head_valid,
    output etc_pkg::cmd_t       head_cmd,
    output etc_pkg::qstat_t     q_stat
);
    import etc_pkg::*;

    cmd_t              entries [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign do_push = push_valid && (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign do_pop  = pop && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head_valid   = (count_reg != '0);
    assign head_cmd     = entries[rd_ptr_reg];
    assign q_stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_stat.count = count_reg;

endmodule
`default_nettype wire

/* rtl/core/etc_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module etc_back (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [etc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [etc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                           head_valid,
    input  wire etc_pkg::cmd_t                   head_cmd,
    output logic                                pop,
    output logic                                result_valid,
    input  wire logic                           result_ready,
    output logic                                found,
    output logic [etc_pkg::TIDX_W-1:0]           trigger_index,
    output logic [etc_pkg::SAMPLE_BITS-1:0]      value
);
    import etc_pkg::*;

    // Configuration registers
    logic [LEVEL_W-1:0] level_reg;
    logic               falling_reg;
    logic [SCALE_W-1:0] scale_reg;

    // Sample store and frame store
    logic [SAMPLE_BITS-1:0] sample_mem [STORE_DEPTH];
    logic [SAMPLE_BITS-1:0] frame_mem  [FRAME_WIDTH];

    back_state_t            state_reg, state_next;
    logic [ADDR_W-1:0]      newest_reg, newest_next;
    logic [FILL_W-1:0]      fill_reg, fill_next;
    logic [ADDR_W-1:0]      cmp_idx_reg, cmp_idx_next;
    logic [SPAN_W-1:0]      cnt_reg, cnt_next;
    logic [SAMPLE_BITS-1:0] next_smp_reg, next_smp_next;
    logic [ADDR_W-1:0]      base_reg, base_next;
    logic [FRAME_AW-1:0]    k_reg, k_next;
    logic [ADDR_W-1:0]      q_reg, q_next;
    logic [5:0]             r_reg, r_next;
    logic [3:0]             step_q_reg, step_q_next;
    logic [4:0]             step_r_reg, step_r_next;
    logic                   wr_pend_reg, wr_pend_next;
    logic [FRAME_AW-1:0]    wr_k_reg, wr_k_next;
    logic                   frame_valid_reg, frame_valid_next;
    logic                   res_found_reg, res_found_next;

    logic                   out_valid_reg, out_valid_next;
    logic                   out_found_reg;
    logic [TIDX_W-1:0]      out_tidx_reg;
    logic [SAMPLE_BITS-1:0] out_value_reg;

    logic [SAMPLE_BITS-1:0] smp_rdata_reg;
    logic                   smp_rvalid_reg;
    logic [SAMPLE_BITS-1:0] frame_rdata_reg;

    logic                   sm_re, sm_we, fr_re;
    logic [ADDR_W-1:0]      sm_addr;
    logic [FRAME_AW-1:0]    fr_addr;
    logic [SAMPLE_BITS-1:0] smp_val;
    logic                   out_free, load_out;
    logic                   ld_found;
    logic [TIDX_W-1:0]      ld_tidx;
    logic [SAMPLE_BITS-1:0] ld_value;
    logic [CMP_W-1:0]       here_ext, next_ext, level_ext;
    logic                   hit;
    logic [8:0]             third_prod;
    logic [3:0]             scale_q;
    logic [SCALE_W-1:0]     scale_r;
    logic [5:0]             r_sum;
    logic                   r_carry;
    logic [5:0]             r_wrap;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg   <= LEVEL_RESET;
            falling_reg <= 1'b0;
            scale_reg   <= SCALE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_LEVEL: level_reg   <= cfg_data[LEVEL_W-1:0];
                CFG_EDGE:  falling_reg <= cfg_data[0];
                CFG_SCALE: scale_reg   <= cfg_data[SCALE_W-1:0];
                default:   ;
            endcase
        end
    end

    // Entries are written in address order from zero after reset, so an entry
    // at or above the fill count has never been written and reads as zero.
    assign smp_val = smp_rvalid_reg ? smp_rdata_reg : '0;

    assign here_ext  = CMP_W'(smp_val);
    assign next_ext  = CMP_W'(next_smp_reg);
    assign level_ext = CMP_W'(level_reg);
    assign hit = falling_reg ? (here_ext > level_ext) && (next_ext <= level_ext)
                             : (here_ext <= level_ext) && (next_ext > level_ext);

    // scale / 24 as (scale / 8) / 3; the factor 11/32 is exact for 5-bit values.
    assign third_prod = 9'(scale_reg[SCALE_W-1:3]) * 9'd11;
    assign scale_q    = third_prod[8:5];
    assign scale_r    = scale_reg - (SCALE_W'(scale_q) << 4) - (SCALE_W'(scale_q) << 3);

    // Running k * scale / 24 kept as quotient and remainder.
    assign r_sum   = r_reg + 6'(step_r_reg);
    assign r_carry = (r_sum >= 6'(SCALE_DIV));
    assign r_wrap  = r_carry ? r_sum - 6'(SCALE_DIV) : r_sum;

    assign out_free = !out_valid_reg || result_ready;

    always_comb
    begin
        state_next       = state_reg;
        newest_next      = newest_reg;
        fill_next        = fill_reg;
        cmp_idx_next     = cmp_idx_reg;
        cnt_next         = cnt_reg;
        next_smp_next    = next_smp_reg;
        base_next        = base_reg;
        k_next           = k_reg;
        q_next           = q_reg;
        r_next           = r_reg;
        step_q_next      = step_q_reg;
        step_r_next      = step_r_reg;
        wr_pend_next     = 1'b0;
        wr_k_next        = wr_k_reg;
        frame_valid_next = frame_valid_reg;
        res_found_next   = res_found_reg;
        pop              = 1'b0;
        sm_re            = 1'b0;
        sm_we            = 1'b0;
        sm_addr          = cmp_idx_reg;
        fr_re            = 1'b0;
        fr_addr          = head_cmd.frame_idx;
        load_out         = 1'b0;
        ld_found         = 1'b0;
        ld_tidx          = '0;
        ld_value         = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    pop = 1'b1;
                    case (head_cmd.kind)
                        KIND_STORE:
                        begin
                            sm_we       = 1'b1;
                            newest_next = newest_reg + 1'b1;
                            if (fill_reg != FILL_W'(STORE_DEPTH))
                            begin
                                fill_next = fill_reg + 1'b1;
                            end
                        end
                        KIND_CAPTURE:
                        begin
                            // Fetch the sample after the first search position.
                            cmp_idx_next = newest_reg - ADDR_W'(HALF_FRAME);
                            sm_re        = 1'b1;
                            sm_addr      = cmp_idx_next + 1'b1;
                            state_next   = ST_PRIME;
                        end
                        KIND_READ:
                        begin
                            fr_re      = 1'b1;
                            state_next = ST_READ;
                        end
                        default: ;
                    endcase
                end
            end

            ST_READ:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    ld_value   = frame_valid_reg ? frame_rdata_reg : '0;
                    state_next = ST_IDLE;
                end
            end

            ST_PRIME:
            begin
                next_smp_next = smp_val;
                sm_re         = 1'b1;
                sm_addr       = cmp_idx_reg;
                cnt_next      = '0;
                state_next    = ST_SEARCH;
            end

            ST_SEARCH:
            begin
                // The read data belongs to cmp_idx_reg; the next lower address
                // is fetched in the same cycle in case there is no crossing.
                if (hit)
                begin
                    res_found_next   = 1'b1;
                    frame_valid_next = 1'b1;
                    base_next        = cmp_idx_reg - ADDR_W'(PRE_TRIGGER);
                    k_next           = '0;
                    q_next           = '0;
                    r_next           = '0;
                    step_q_next      = scale_q;
                    step_r_next      = scale_r[4:0];
                    state_next       = ST_COPY;
                end
                else if (cnt_reg == SPAN_W'(SEARCH_SPAN - 1))
                begin
                    res_found_next = 1'b0;
                    state_next     = ST_DONE;
                end
                else
                begin
                    next_smp_next = smp_val;
                    sm_re         = 1'b1;
                    sm_addr       = cmp_idx_reg - 1'b1;
                    cmp_idx_next  = cmp_idx_reg - 1'b1;
                    cnt_next      = cnt_reg + 1'b1;
                end
            end

            ST_COPY:
            begin
                sm_re        = 1'b1;
                sm_addr      = base_reg + q_reg;
                wr_pend_next = 1'b1;
                wr_k_next    = k_reg;
                k_next       = k_reg + 1'b1;
                q_next       = q_reg + ADDR_W'(step_q_reg) + ADDR_W'(r_carry);
                r_next       = r_wrap;
                if (k_reg == FRAME_AW'(FRAME_WIDTH - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end

            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    ld_found   = res_found_reg;
                    ld_tidx    = res_found_reg ? TIDX_W'(cmp_idx_reg) : '0;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            newest_reg      <= ADDR_W'(STORE_DEPTH - 1);
            fill_reg        <= '0;
            wr_pend_reg     <= 1'b0;
            frame_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            smp_rvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            newest_reg      <= newest_next;
            fill_reg        <= fill_next;
            wr_pend_reg     <= wr_pend_next;
            frame_valid_reg <= frame_valid_next;
            out_valid_reg   <= out_valid_next;
            if (sm_re)
            begin
                smp_rvalid_reg <= ({1'b0, sm_addr} < fill_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg   <= cmp_idx_next;
        cnt_reg       <= cnt_next;
        next_smp_reg  <= next_smp_next;
        base_reg      <= base_next;
        k_reg         <= k_next;
        q_reg         <= q_next;
        r_reg         <= r_next;
        step_q_reg    <= step_q_next;
        step_r_reg    <= step_r_next;
        wr_k_reg      <= wr_k_next;
        res_found_reg <= res_found_next;
        if (load_out)
        begin
            out_found_reg <= ld_found;
            out_tidx_reg  <= ld_tidx;
            out_value_reg <= ld_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sm_we)
        begin
            sample_mem[newest_next] <= head_cmd.sample;
        end
        if (sm_re)
        begin
            smp_rdata_reg <= sample_mem[sm_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_pend_reg)
        begin
            frame_mem[wr_k_reg] <= smp_val;
        end
        if (fr_re)
        begin
            frame_rdata_reg <= frame_mem[fr_addr];
        end
    end

    assign result_valid  = out_valid_reg;
    assign found         = out_found_reg;
    assign trigger_index = out_tidx_reg;
    assign value         = out_value_reg;

endmodule
`default_nettype wire

/* sim/edge_trigger_capture_top_tb.sv */
`timescale 1ns / 1ps
module edge_trigger_capture_top_tb;
    import etc_pkg::*;

    // Code 3 is not used by the block; it must be ignored.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int WATCHDOG_LIMIT = 10000;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 16;
    localparam int RANDOM_ITEMS   = 600;
    localparam int TRACE_SAMPLES  = 400;
    localparam int SAMPLE_MAX     = (1 << SAMPLE_BITS) - 1;
    localparam int LEVEL_MAX      = (1 << LEVEL_W) - 1;
    localparam int SCALE_MAX      = (1 << SCALE_W) - 1;

    typedef enum int {
        WAVE_SQUARE,
        WAVE_TRIANGLE,
        WAVE_NOISE,
        WAVE_FLAT
    } wave_t;

    typedef struct packed {
        logic                   found;
        logic [TIDX_W-1:0]      tidx;
        logic [SAMPLE_BITS-1:0] value;
    } readout_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   item_valid;
    logic                   item_ready;
    logic [OP_W-1:0]        op;
    logic [SAMPLE_BITS-1:0] sample;
    logic [READ_W-1:0]      read_index;
    logic                   result_valid;
    logic                   result_ready;
    logic                   found;
    logic [TIDX_W-1:0]      trigger_index;
    logic [SAMPLE_BITS-1:0] value;

    // Mirror of the scope state and its registers.
    logic [SAMPLE_BITS-1:0] trace_mem [STORE_DEPTH];
    logic [ADDR_W-1:0]      trace_head;
    logic [SAMPLE_BITS-1:0] frame_mem [FRAME_WIDTH];
    logic [LEVEL_W-1:0]     trig_level;
    logic                   trig_falling;
    logic [SCALE_W-1:0]     trig_scale;
    readout_t               awaited_readouts [$];

    int  mismatches      = 0;
    int  readouts_seen   = 0;
    int  effective_items = 0;
    int  captures_hit    = 0;
    int  captures_missed = 0;
    int  frame_reads     = 0;
    int  settings_used   = 0;
    int  quiet_cycles    = 0;
    bit  tx_steady       = 1'b0;
    bit  rx_steady       = 1'b0;
    bit  hold_results    = 1'b0;

    edge_trigger_capture_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .op            (op),
        .sample        (sample),
        .read_index    (read_index),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .found         (found),
        .trigger_index (trigger_index),
        .value         (value)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic void reset_scope_mirror();
        for (int a = 0; a < STORE_DEPTH; a++)
            trace_mem[a] = '0;
        for (int k = 0; k < FRAME_WIDTH; k++)
            frame_mem[k] = '0;
        trace_head   = ADDR_W'(STORE_DEPTH - 1);
        trig_level   = LEVEL_RESET;
        trig_falling = 1'b0;
        trig_scale   = SCALE_RESET;
    endfunction

    function automatic bit crosses_level(int unsigned pos);
        logic [SAMPLE_BITS-1:0] here;
        logic [SAMPLE_BITS-1:0] after;
        here  = trace_mem[pos % STORE_DEPTH];
        after = trace_mem[(pos + 1) % STORE_DEPTH];
        if (trig_falling)
            return (here > trig_level) && (after <= trig_level);
        return (here <= trig_level) && (after > trig_level);
    endfunction

    // Applies one accepted item to the mirror and queues the readout it causes.
    function automatic void run_scope_op(logic [OP_W-1:0] code, logic [SAMPLE_BITS-1:0] smp,
                                         logic [READ_W-1:0] ridx);
        readout_t    res;
        int unsigned pos;
        int unsigned origin;
        bit          hit;
        res = '0;
        hit = 1'b0;
        if (code != OP_UNUSED)
            effective_items++;
        case (code)
            OP_STORE:
            begin
                trace_head = trace_head + 1'b1;
                trace_mem[trace_head] = smp;
            end
            OP_CAPTURE:
            begin
                pos = (trace_head + STORE_DEPTH - HALF_FRAME) % STORE_DEPTH;
                for (int n = 0; n < SEARCH_SPAN && !hit; n++)
                begin
                    if (crosses_level(pos))
                        hit = 1'b1;
                    else
                        pos = (pos + STORE_DEPTH - 1) % STORE_DEPTH;
                end
                if (hit)
                begin
                    origin = (pos + STORE_DEPTH - PRE_TRIGGER) % STORE_DEPTH;
                    for (int k = 0; k < FRAME_WIDTH; k++)
                        frame_mem[k] = trace_mem[(origin + (k * trig_scale) / SCALE_DIV)
                                                 % STORE_DEPTH];
                    res.found = 1'b1;
                    res.tidx  = TIDX_W'(pos);
                    captures_hit++;
                end
                else
                    captures_missed++;
                awaited_readouts.push_back(res);
            end
            OP_READ:
            begin
                res.value = frame_mem[ridx % FRAME_WIDTH];
                frame_reads++;
                awaited_readouts.push_back(res);
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic send_item(input logic [OP_W-1:0] code, input logic [SAMPLE_BITS-1:0] smp,
                             input logic [READ_W-1:0] ridx);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        op         <= code;
        sample     <= smp;
        read_index <= ridx;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        run_scope_op(code, smp, ridx);
    endtask

    task automatic push_sample(input logic [SAMPLE_BITS-1:0] smp);
        send_item(OP_STORE, smp, READ_W'($urandom_range(0, FRAME_WIDTH - 1)));
    endtask

    task automatic request_capture();
        send_item(OP_CAPTURE, SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)),
                  READ_W'($urandom_range(0, FRAME_WIDTH - 1)));
    endtask

    task automatic read_frame(input int pos);
        send_item(OP_READ, SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)), READ_W'(pos));
    endtask

    task automatic send_ignored();
        send_item(OP_UNUSED, SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)),
                  READ_W'($urandom_range(0, FRAME_WIDTH - 1)));
    endtask

    // Lets the block run dry so that registers can be written safely.
    task automatic settle_block();
        item_valid <= 1'b0;
        while (awaited_readouts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input int level, input bit falling, input int scale);
        cfg_write <= 1'b1;
        cfg_index <= CFG_LEVEL;
        cfg_data  <= CFG_DATA_W'(level);
        @(posedge clk);
        cfg_index <= CFG_EDGE;
        cfg_data  <= CFG_DATA_W'(falling);
        @(posedge clk);
        cfg_index <= CFG_SCALE;
        cfg_data  <= CFG_DATA_W'(scale);
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        trig_level   = LEVEL_W'(level);
        trig_falling = falling;
        trig_scale   = SCALE_W'(scale);
        settings_used++;
    endtask

    function automatic logic [SAMPLE_BITS-1:0] wave_point(wave_t shape, int k, int period,
                                                          int lo, int hi);
        int half;
        int phase;
        half  = period / 2;
        phase = k % period;
        case (shape)
            WAVE_SQUARE:
                return SAMPLE_BITS'((phase < half) ? lo : hi);
            WAVE_TRIANGLE:
                if (phase < half)
                    return SAMPLE_BITS'(lo + (hi - lo) * phase / half);
                else
                    return SAMPLE_BITS'(hi - (hi - lo) * (phase - half) / (period - half));
            WAVE_NOISE:
                return SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
            default:
                return SAMPLE_BITS'(lo);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH readout %0d, %s: got %0d, expected %0d",
                 readouts_seen, what, got, want);
        mismatches++;
    endtask

    // Receiver: random stalls, with an occasional long hold-off on request.
    initial
    begin
        int stall;
        result_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_results)
            begin
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_results = 1'b0;
            end
            else
            begin
                stall = rx_steady ? 0 : pick_gap();
                if (stall > 0)
                begin
                    result_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                result_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : check_readouts
        readout_t want;
        if (rst_n === 1'b1 && result_valid && result_ready)
        begin
            readouts_seen++;
            if (awaited_readouts.size() == 0)
                report_mismatch("readout with nothing outstanding", int'(found), 0);
            else
            begin
                want = awaited_readouts.pop_front();
                if (found !== want.found)
                    report_mismatch("found", int'(found), int'(want.found));
                if (trigger_index !== want.tidx)
                    report_mismatch("trigger_index", int'(trigger_index), int'(want.tidx));
                if (value !== want.value)
                    report_mismatch("value", int'(value), int'(want.value));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles, %0d readouts outstanding",
                     quiet_cycles, awaited_readouts.size());
            $display("edge_trigger_capture_top_tb NOT OK");
            $finish;
        end
    end

    // Fresh state: zero frame, empty trace, nothing to trigger on.
    task automatic test_after_reset();
        read_frame(0);
        read_frame(FRAME_WIDTH - 1);
        request_capture();
        send_ignored();
        read_frame(HALF_FRAME);
        settle_block();
    endtask

    // Square wave at the sample extremes, both polarities, level and scale extremes.
    task automatic test_edge_polarity();
        rx_steady = 1'b1;
        for (int k = 0; k < 100; k++)
            push_sample(SAMPLE_BITS'(((k / 8) % 2) ? SAMPLE_MAX : 0));
        request_capture();
        read_frame(0);
        read_frame(FRAME_WIDTH - 1);
        settle_block();
        rx_steady = 1'b0;
        // A zero scale copies the same pre-trigger sample into every position.
        configure(int'(LEVEL_RESET), 1'b1, 0);
        request_capture();
        read_frame(0);
        read_frame(FRAME_WIDTH - 1);
        settle_block();
        configure(0, 1'b0, SCALE_MAX);
        request_capture();
        read_frame(FRAME_WIDTH - 1);
        read_frame(1);
        settle_block();
        // Nothing can cross the top level, so the old frame must survive.
        configure(LEVEL_MAX, 1'b0, 1);
        request_capture();
        read_frame(FRAME_WIDTH - 1);
        settle_block();
        configure(LEVEL_MAX, 1'b1, 1);
        request_capture();
        read_frame(5);
        settle_block();
    endtask

    // A long triangle trace at a wide time scale, then the whole frame read back.
    task automatic test_store_wrap();
        configure(300, 1'b1, 200);
        tx_steady = 1'b1;
        for (int k = 0; k < TRACE_SAMPLES; k++)
            push_sample(wave_point(WAVE_TRIANGLE, k, 46, 0, SAMPLE_MAX));
        tx_steady = 1'b0;
        request_capture();
        for (int k = 0; k < FRAME_WIDTH; k++)
            read_frame(k);
        settle_block();
    endtask

    // The receiver holds off while the sender keeps going, so the input stalls.
    task automatic test_backpressure();
        configure(int'(LEVEL_RESET), 1'b0, int'(SCALE_RESET));
        hold_results = 1'b1;
        tx_steady    = 1'b1;
        for (int j = 0; j < 24; j++)
        begin
            if (j % 6 == 0)
                request_capture();
            else
                read_frame($urandom_range(0, FRAME_WIDTH - 1));
        end
        tx_steady = 1'b0;
        settle_block();
    endtask

    task automatic test_random_traffic();
        int    start_items;
        int    level;
        int    scale;
        int    lo;
        int    hi;
        int    period;
        int    k;
        int    roll;
        wave_t shape;
        start_items = effective_items;
        while (effective_items - start_items < RANDOM_ITEMS)
        begin
            settle_block();
            roll  = $urandom_range(0, 9);
            level = (roll == 0) ? 0 : (roll == 1) ? LEVEL_MAX : $urandom_range(0, LEVEL_MAX);
            roll  = $urandom_range(0, 9);
            case (roll)
                0: scale = 0;
                1: scale = 1;
                2: scale = SCALE_MAX;
                3: scale = int'(SCALE_RESET);
                default: scale = $urandom_range(1, SCALE_MAX);
            endcase
            configure(level, 1'($urandom_range(0, 1)), scale);
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            shape  = wave_t'($urandom_range(WAVE_SQUARE, WAVE_FLAT));
            period = $urandom_range(4, 60);
            lo     = $urandom_range(0, level);
            hi     = (level == LEVEL_MAX) ? LEVEL_MAX : $urandom_range(level + 1, LEVEL_MAX);
            // A falling trigger needs the flat trace above the level to stay quiet.
            if (shape == WAVE_FLAT && $urandom_range(0, 1))
                lo = hi;
            k = 0;
            repeat ($urandom_range(HALF_FRAME + 2, 130))
            begin
                push_sample(wave_point(shape, k, period, lo, hi));
                k++;
                roll = $urandom_range(0, 39);
                if (roll == 0)
                    send_ignored();
                else if (roll == 1)
                    read_frame($urandom_range(0, FRAME_WIDTH - 1));
            end
            repeat ($urandom_range(2, 4))
            begin
                repeat ($urandom_range(0, 25))
                begin
                    push_sample(wave_point(shape, k, period, lo, hi));
                    k++;
                end
                request_capture();
                repeat ($urandom_range(2, 6))
                    read_frame($urandom_range(0, FRAME_WIDTH - 1));
                if ($urandom_range(0, 4) == 0)
                    send_ignored();
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        cfg_write  <= 1'b0;
        cfg_index  <= CFG_LEVEL;
        cfg_data   <= '0;
        item_valid <= 1'b0;
        op         <= OP_STORE;
        sample     <= '0;
        read_index <= '0;
        reset_scope_mirror();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_after_reset();
        test_edge_polarity();
        test_store_wrap();
        test_backpressure();
        test_random_traffic();
        settle_block();

        $display("Run covered %0d items: %0d captures with a trigger, %0d without, %0d reads.",
                 effective_items, captures_hit, captures_missed, frame_reads);
        $display("It used %0d register settings, searched and copied across address zero %s",
                 settings_used, "and held off readouts.");
        if (mismatches == 0)
            $display("edge_trigger_capture_top_tb OK");
        else
            $display("edge_trigger_capture_top_tb NOT OK");
        $finish;
    end

endmodule

/* files.f */
rtl/core/etc_pkg.sv
rtl/core/etc_front.sv
rtl/core/etc_queue.sv
rtl/core/etc_back.sv
rtl/core/edge_trigger_capture_top.sv
sim/edge_trigger_capture_top_tb.sv
